>>> design/fpge_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the framebuffer pixel and glyph engine.
// No dependencies; the front, queue, back and top files import this package.
package fpge_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int GLYPH_CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 48;
  localparam int OFFSET_W    = 34;

  localparam logic [7:0]  BPP_RESET  = 8'd32;
  localparam logic [23:0] RGB24_MASK = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_GLYPH   = 2'd2,
    OP_PRESENT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_WIDTH     = 3'd0,
    REG_FB_HEIGHT    = 3'd1,
    REG_LINE_PITCH   = 3'd2,
    REG_BITS_PER_PIX = 3'd3,
    REG_SURFACE_BASE = 3'd4,
    REG_LINK_READY   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] fb_width;
    logic [15:0] fb_height;
    logic [15:0] line_pitch;
    logic [7:0]  bits_per_pixel;
    logic [31:0] surface_base;
    logic        link_ready;
  } cfg_t;

  // One classified command as it waits between the front and back parts.
  typedef struct packed {
    op_t                    op;
    logic [15:0]            x;
    logic [15:0]            y;
    logic [15:0]            w;
    logic [15:0]            h;
    logic [31:0]            fg;
    logic [31:0]            bg;
    logic [7:0]             bits;
    logic [GLYPH_CNT_W-1:0] count;
    logic [31:0]            raw;
  } cmd_t;

  typedef struct packed {
    logic              write_enable;
    logic              in_range;
    logic [ADDR_W-1:0] mem_address;
    logic [2:0]        byte_count;
    logic [31:0]       write_data;
    logic [23:0]       read_color;
    logic [15:0]       clip_width;
    logic [15:0]       clip_height;
    logic [ADDR_W-1:0] transfer_offset;
    logic              last_result;
  } res_t;

endpackage

>>> design/fpge_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the framebuffer pixel and glyph engine: command input,
// result output and configuration write. Depends on nothing.

interface fpge_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] rect_w;
  logic [15:0] rect_h;
  logic [31:0] fg_color;
  logic [31:0] back_color;
  logic [7:0]  glyph_bits;
  logic [4:0]  glyph_width;
  logic [7:0]  glyph_row;
  logic [31:0] raw_pixel;

  modport source (
    output valid, opcode, pos_x, pos_y, rect_w, rect_h, fg_color, back_color,
           glyph_bits, glyph_width, glyph_row, raw_pixel,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, rect_w, rect_h, fg_color, back_color,
           glyph_bits, glyph_width, glyph_row, raw_pixel,
    output ready
  );
endinterface

interface fpge_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic        in_range;
  logic [47:0] mem_address;
  logic [2:0]  byte_count;
  logic [31:0] write_data;
  logic [23:0] read_color;
  logic [15:0] clip_width;
  logic [15:0] clip_height;
  logic [47:0] transfer_offset;
  logic        last_result;

  modport source (
    output valid, write_enable, in_range, mem_address, byte_count, write_data,
           read_color, clip_width, clip_height, transfer_offset, last_result,
    input  ready
  );
  modport sink (
    input  valid, write_enable, in_range, mem_address, byte_count, write_data,
           read_color, clip_width, clip_height, transfer_offset, last_result,
    output ready
  );
endinterface

interface fpge_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/fpge_front.sv
`timescale 1ns / 1ps
// Front part: takes command words, saturates the glyph width, forms the glyph
// row coordinate and drops empty glyph rows. Depends on fpge_pkg and fpge_if.
module fpge_front import fpge_pkg::*; #(
  parameter int GLYPH_MAX_WIDTH = 16
) (
  fpge_in_if.sink    in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  op_t                    op;
  logic [GLYPH_CNT_W-1:0] count;

  assign op = op_t'(in_ch.opcode);

  always_comb begin
    if (int'(in_ch.glyph_width) > GLYPH_MAX_WIDTH) begin
      count = GLYPH_CNT_W'(GLYPH_MAX_WIDTH);
    end else begin
      count = in_ch.glyph_width;
    end
  end

  always_comb begin
    push_cmd.op    = op;
    push_cmd.x     = in_ch.pos_x;
    push_cmd.y     = (op == OP_GLYPH) ? in_ch.pos_y + 16'(in_ch.glyph_row) : in_ch.pos_y;
    push_cmd.w     = in_ch.rect_w;
    push_cmd.h     = in_ch.rect_h;
    push_cmd.fg    = in_ch.fg_color;
    push_cmd.bg    = in_ch.back_color;
    push_cmd.bits  = in_ch.glyph_bits;
    push_cmd.count = count;
    push_cmd.raw   = in_ch.raw_pixel;
  end

  // A glyph row of width zero is taken but produces nothing downstream.
  assign push_valid  = in_ch.valid && !(op == OP_GLYPH && count == '0);
  assign in_ch.ready = push_ready;

endmodule

>>> design/fpge_cmd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on fpge_pkg for the command type and queue depth.
module fpge_cmd_queue import fpge_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/fpge_back.sv
`timescale 1ns / 1ps
// Back part: steps glyph columns, bounds-checks, multiplies out the pixel
// offset, packs colors and holds the result word. Depends on fpge_pkg, fpge_if.
module fpge_back import fpge_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_cmd,
  fpge_out_if.source out_ch
);

  localparam int PRODX_W = 21;

  logic adv;

  // Issue stage: one pixel or command per cycle while out_ch is not stalled.
  logic                   more, take, on;
  logic [GLYPH_CNT_W-1:0] col_r, col_nxt;
  logic                   s1_vld_r;
  op_t                    s1_op_r;
  logic [15:0]            s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic [31:0]            s1_color_r, s1_raw_r;
  logic                   s1_last_r;

  // Multiply and classify stage.
  logic [4:0]         bytes_pp;
  logic [2:0]         acc_size;
  logic               pt_in, pres_ok;
  logic [16:0]        end_x, end_y, clip_x, clip_y;
  logic               s2_vld_r, s2_ok_r, s2_last_r;
  op_t                s2_op_r;
  logic [31:0]        s2_prod_y_r, s2_prod_y_nxt;
  logic [PRODX_W-1:0] s2_prod_x_r, s2_prod_x_nxt;
  logic [2:0]         s2_bc_r;
  logic [31:0]        s2_wd_r, s2_wd_nxt;
  logic [23:0]        s2_rc_r, s2_rc_nxt;
  logic [15:0]        s2_cw_r, s2_ch_r;

  // Output stage.
  logic [OFFSET_W-1:0] offset;
  logic [ADDR_W-1:0]   addr;
  logic                out_vld_r;
  res_t                out_res_r, out_res_nxt;

  assign adv = !out_vld_r || out_ch.ready;

  always_comb begin
    more      = (pop_cmd.op == OP_GLYPH) && ((col_r + 1'b1) < pop_cmd.count);
    take      = adv && pop_valid;
    pop_ready = adv && !more;
    on        = (col_r < GLYPH_CNT_W'(8)) && pop_cmd.bits[3'd7 - col_r[2:0]];
    col_nxt   = col_r;
    if (take) begin
      col_nxt = more ? col_r + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      if (adv) begin
        s1_vld_r  <= take;
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r    <= pop_cmd.op;
      s1_x_r     <= pop_cmd.x + 16'(col_r);
      s1_y_r     <= pop_cmd.y;
      s1_w_r     <= pop_cmd.w;
      s1_h_r     <= pop_cmd.h;
      s1_color_r <= (pop_cmd.op == OP_GLYPH && !on) ? pop_cmd.bg : pop_cmd.fg;
      s1_raw_r   <= pop_cmd.raw;
      s1_last_r  <= !more;
    end
  end

  // A depth under eight bits counts as four bytes per pixel.
  always_comb begin
    bytes_pp = (cfg.bits_per_pixel[7:3] == '0) ? 5'd4 : cfg.bits_per_pixel[7:3];
    acc_size = (bytes_pp == 5'd2 || bytes_pp == 5'd3) ? bytes_pp[2:0] : 3'd4;
    pt_in    = (s1_x_r < cfg.fb_width) && (s1_y_r < cfg.fb_height);
    pres_ok  = cfg.link_ready && (s1_w_r != '0) && (s1_h_r != '0) && pt_in;
    end_x    = {1'b0, s1_x_r} + {1'b0, s1_w_r};
    end_y    = {1'b0, s1_y_r} + {1'b0, s1_h_r};
    clip_x   = (end_x > {1'b0, cfg.fb_width}) ? {1'b0, cfg.fb_width} : end_x;
    clip_y   = (end_y > {1'b0, cfg.fb_height}) ? {1'b0, cfg.fb_height} : end_y;

    s2_prod_y_nxt = 32'(s1_y_r) * 32'(cfg.line_pitch);
    s2_prod_x_nxt = PRODX_W'(s1_x_r) * PRODX_W'(bytes_pp);

    if (bytes_pp == 5'd2) begin
      s2_wd_nxt = {16'h0000, s1_color_r[23:19], s1_color_r[15:10], s1_color_r[7:3]};
      s2_rc_nxt = {s1_raw_r[15:11], 3'b000, s1_raw_r[10:5], 2'b00, s1_raw_r[4:0], 3'b000};
    end else begin
      s2_wd_nxt = {8'h00, s1_color_r[23:0] & RGB24_MASK};
      s2_rc_nxt = s1_raw_r[23:0] & RGB24_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r     <= s1_op_r;
      s2_ok_r     <= (s1_op_r == OP_PRESENT) ? pres_ok : pt_in;
      s2_last_r   <= s1_last_r;
      s2_prod_y_r <= s2_prod_y_nxt;
      s2_prod_x_r <= s2_prod_x_nxt;
      s2_bc_r     <= acc_size;
      s2_wd_r     <= s2_wd_nxt;
      s2_rc_r     <= s2_rc_nxt;
      s2_cw_r     <= 16'(clip_x - {1'b0, s1_x_r});
      s2_ch_r     <= 16'(clip_y - {1'b0, s1_y_r});
    end
  end

  always_comb begin
    offset      = {2'b00, s2_prod_y_r} + OFFSET_W'(s2_prod_x_r);
    addr        = ADDR_W'(cfg.surface_base) + ADDR_W'(offset);
    out_res_nxt = '0;
    out_res_nxt.last_result = s2_last_r;
    if (s2_ok_r) begin
      unique case (s2_op_r)
        OP_WRITE, OP_GLYPH: begin
          out_res_nxt.write_enable = 1'b1;
          out_res_nxt.in_range     = 1'b1;
          out_res_nxt.mem_address  = addr;
          out_res_nxt.byte_count   = s2_bc_r;
          out_res_nxt.write_data   = s2_wd_r;
        end
        OP_READ: begin
          out_res_nxt.in_range    = 1'b1;
          out_res_nxt.mem_address = addr;
          out_res_nxt.byte_count  = s2_bc_r;
          out_res_nxt.read_color  = s2_rc_r;
        end
        OP_PRESENT: begin
          out_res_nxt.in_range        = 1'b1;
          out_res_nxt.clip_width      = s2_cw_r;
          out_res_nxt.clip_height     = s2_ch_r;
          out_res_nxt.transfer_offset = ADDR_W'(offset);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.write_enable    = out_res_r.write_enable;
  assign out_ch.in_range        = out_res_r.in_range;
  assign out_ch.mem_address     = out_res_r.mem_address;
  assign out_ch.byte_count      = out_res_r.byte_count;
  assign out_ch.write_data      = out_res_r.write_data;
  assign out_ch.read_color      = out_res_r.read_color;
  assign out_ch.clip_width      = out_res_r.clip_width;
  assign out_ch.clip_height     = out_res_r.clip_height;
  assign out_ch.transfer_offset = out_res_r.transfer_offset;
  assign out_ch.last_result     = out_res_r.last_result;

endmodule

>>> design/framebuffer_pixel_glyph_engine.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake    | Word
// in_ch    | in  | valid/ready  | one command: pixel write/read, glyph row, present rect
// out_ch   | out | valid/ready  | one result; last_result closes each command
// cfg_ch   | in  | valid/ready  | register index and data, always ready
//
// Each command word becomes one result, a glyph row one result per pixel; the
// back pipeline delivers one result per cycle while out_ch is not stalled. A
// word taken from the queue passes the issue, multiply and output registers
// before it reaches out_ch. Synchronous active-low reset empties the queue and
// pipeline and loads register defaults. A stalled out_ch freezes the back
// pipeline while the front keeps filling the two-entry command queue.
// Depends on fpge_pkg, fpge_if, fpge_front, fpge_cmd_queue and fpge_back.
module framebuffer_pixel_glyph_engine import fpge_pkg::*; #(
  parameter int GLYPH_MAX_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fpge_in_if.sink    in_ch,
  fpge_out_if.source out_ch,
  fpge_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width       <= '0;
      cfg_r.fb_height      <= '0;
      cfg_r.line_pitch     <= '0;
      cfg_r.bits_per_pixel <= BPP_RESET;
      cfg_r.surface_base   <= '0;
      cfg_r.link_ready     <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_FB_WIDTH:     cfg_r.fb_width       <= cfg_ch.data[15:0];
        REG_FB_HEIGHT:    cfg_r.fb_height      <= cfg_ch.data[15:0];
        REG_LINE_PITCH:   cfg_r.line_pitch     <= cfg_ch.data[15:0];
        REG_BITS_PER_PIX: cfg_r.bits_per_pixel <= cfg_ch.data[7:0];
        REG_SURFACE_BASE: cfg_r.surface_base   <= cfg_ch.data;
        REG_LINK_READY:   cfg_r.link_ready     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  fpge_front #(
    .GLYPH_MAX_WIDTH(GLYPH_MAX_WIDTH)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fpge_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fpge_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule
